// ===== rtl/bdq_pkg.sv =====
// ----------------------------------------------------------------------------
// bdq_pkg
// Shared constants, codes and types of the bounded deque with index read.
// ----------------------------------------------------------------------------
package bdq_pkg;

  localparam int unsigned Capacity = 256;
  localparam int unsigned AddrW    = $clog2(Capacity);
  localparam int unsigned CountW   = $clog2(Capacity + 1);
  localparam int unsigned DataW    = 32;
  localparam int unsigned PosW     = 16;
  localparam int unsigned OccW     = 9;
  localparam int unsigned FuncW    = 3;
  localparam int unsigned StatusW  = 2;

  typedef logic [AddrW-1:0]  addr_t;
  typedef logic [CountW-1:0] count_t;

  typedef enum logic [FuncW-1:0] {
    FuncPushFront = 3'd0,
    FuncPushBack  = 3'd1,
    FuncPopFront  = 3'd2,
    FuncPopBack   = 3'd3,
    FuncReadIndex = 3'd4
  } func_e;

  typedef enum logic [StatusW-1:0] {
    StatusDone  = 2'd0,
    StatusEmpty = 2'd1,
    StatusFull  = 2'd2
  } status_e;

  typedef struct packed {
    logic                    en;
    addr_t                   addr;
    logic signed [DataW-1:0] data;
  } mem_wr_t;

  typedef struct packed {
    logic  en;
    addr_t addr;
  } mem_rd_t;

  // both operands below the capacity, so one conditional subtract wraps
  function automatic addr_t ring_add(addr_t a, addr_t b);
    logic [AddrW:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s >= (AddrW + 1)'(Capacity)) begin
      s = s - (AddrW + 1)'(Capacity);
    end
    return s[AddrW-1:0];
  endfunction

endpackage

// ===== rtl/bdq_if.sv =====
// ----------------------------------------------------------------------------
// bdq_req_if / bdq_rsp_if
// Valid/ready channels for operation items and result items.
// ----------------------------------------------------------------------------
interface bdq_req_if;
  import bdq_pkg::*;

  logic                    valid;
  logic                    ready;
  logic [FuncW-1:0]        func;
  logic signed [DataW-1:0] value;
  logic [PosW-1:0]         position;

  modport source (output valid, func, value, position, input ready);
  modport sink   (input valid, func, value, position, output ready);
endinterface

interface bdq_rsp_if;
  import bdq_pkg::*;

  logic                    valid;
  logic                    ready;
  logic signed [DataW-1:0] read_value;
  logic [StatusW-1:0]      status;
  logic [OccW-1:0]         occupancy;

  modport source (output valid, read_value, status, occupancy, input ready);
  modport sink   (input valid, read_value, status, occupancy, output ready);
endinterface

// ===== rtl/bdq_store.sv =====
// ----------------------------------------------------------------------------
// bdq_store
// Element memory: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module bdq_store (
  input  logic                             clk_i,
  input  bdq_pkg::mem_wr_t                 wr_i,
  input  bdq_pkg::mem_rd_t                 rd_i,
  output logic signed [bdq_pkg::DataW-1:0] rdata_o
);
  import bdq_pkg::*;

  logic signed [DataW-1:0] mem [Capacity];
  logic signed [DataW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem[wr_i.addr] <= wr_i.data;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_i.en) begin
      rdata_q <= mem[rd_i.addr];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/bounded_deque_with_index_read_core.sv =====
// ----------------------------------------------------------------------------
// bounded_deque_with_index_read_core
// Double-ended queue of signed 32-bit values in a 256-entry ring buffer.
//
// Items enter on req_i: push front, push back, pop front, pop back or read
// at a position counted from the front. Every item gives one result item on
// rsp_o with the read value, a status and the occupancy after the operation.
// Pushes into a full queue are dropped (status full), pops of an empty queue
// and reads past the count are flagged (status empty, read value -1 for the
// read).
// Head and count update at acceptance and the element memory read issues in
// the same cycle, its registered data forming the result. One item is accepted
// every cycle while rsp_o does not stall; a write and a later read of the
// same entry always fall on different edges, so no forwarding is needed.
// The result register keeps accepting while rsp_o is taken in the same cycle;
// when the receiver stalls, the result holds and req_i.ready drops.
// Reset empties the queue and clears the front slot; no clearing pass runs.
// ----------------------------------------------------------------------------
module bounded_deque_with_index_read_core (
  input  logic      clk_i,
  input  logic      rst_ni,
  bdq_req_if.sink   req_i,
  bdq_rsp_if.source rsp_o
);
  import bdq_pkg::*;

  addr_t   front_q, front_d;
  count_t  count_q, count_d;
  logic    out_vld_q;
  status_e status_d, status_q;
  logic    rd_ok_d, rd_ok_q;
  logic    rd_err_d, rd_err_q;
  logic [OccW-1:0] occ_q;
  mem_wr_t wr;
  mem_rd_t rd;
  logic    accept;
  logic    full, empty;
  logic signed [DataW-1:0] rdata;

  assign req_i.ready = !out_vld_q || rsp_o.ready;
  assign accept      = req_i.valid && req_i.ready;
  assign full        = (count_q >= CountW'(Capacity));
  assign empty       = (count_q == '0);

  always_comb begin
    front_d  = front_q;
    count_d  = count_q;
    status_d = StatusDone;
    rd_ok_d  = 1'b0;
    rd_err_d = 1'b0;
    wr.en    = 1'b0;
    wr.addr  = front_q;
    wr.data  = req_i.value;
    rd.en    = 1'b0;
    rd.addr  = ring_add(front_q, req_i.position[AddrW-1:0]);
    unique case (req_i.func)
      FuncPushFront: begin
        if (full) begin
          status_d = StatusFull;
        end else begin
          front_d = ring_add(front_q, AddrW'(Capacity - 1));
          wr.en   = accept;
          wr.addr = front_d;
          count_d = count_q + 1'b1;
        end
      end
      FuncPushBack: begin
        if (full) begin
          status_d = StatusFull;
        end else begin
          wr.en   = accept;
          wr.addr = ring_add(front_q, count_q[AddrW-1:0]);
          count_d = count_q + 1'b1;
        end
      end
      FuncPopFront: begin
        if (empty) begin
          status_d = StatusEmpty;
        end else begin
          front_d = ring_add(front_q, AddrW'(1));
          count_d = count_q - 1'b1;
        end
      end
      FuncPopBack: begin
        if (empty) begin
          status_d = StatusEmpty;
        end else begin
          count_d = count_q - 1'b1;
        end
      end
      FuncReadIndex: begin
        if (req_i.position >= PosW'(count_q)) begin
          status_d = StatusEmpty;
          rd_err_d = 1'b1;
        end else begin
          rd_ok_d = 1'b1;
          rd.en   = accept;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      front_q   <= '0;
      count_q   <= '0;
      out_vld_q <= 1'b0;
    end else begin
      if (accept) begin
        front_q <= front_d;
        count_q <= count_d;
      end
      if (accept) begin
        out_vld_q <= 1'b1;
      end else if (rsp_o.ready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      status_q <= status_d;
      rd_ok_q  <= rd_ok_d;
      rd_err_q <= rd_err_d;
      occ_q    <= OccW'(count_d);
    end
  end

  bdq_store u_store (
    .clk_i   (clk_i),
    .wr_i    (wr),
    .rd_i    (rd),
    .rdata_o (rdata)
  );

  assign rsp_o.valid      = out_vld_q;
  assign rsp_o.read_value = rd_ok_q ? rdata : (rd_err_q ? '1 : '0);
  assign rsp_o.status     = status_q;
  assign rsp_o.occupancy  = occ_q;

endmodule

// ===== test/bounded_deque_with_index_read_core_test.sv =====
// ----------------------------------------------------------------------------
// bounded_deque_with_index_read_core_test
// Self-checking bench for the bounded deque with index read. A local model
// of the ring buffer predicts one result item per operation item. The bench
// covers empty and full edges, front slot wrap, out-of-range reads and spare
// codes, with random gaps on requests and random stalls on results.
// ----------------------------------------------------------------------------
module bounded_deque_with_index_read_core_test;
  import bdq_pkg::*;

  localparam int unsigned CycleLimit = 200000;
  localparam int unsigned MaxReports = 10;

  typedef struct {
    logic [FuncW-1:0]        func;
    logic signed [DataW-1:0] value;
    logic [PosW-1:0]         position;
    int unsigned             gap;
    bit                      hold;
  } op_item_t;

  typedef struct {
    logic signed [DataW-1:0] read_value;
    logic [StatusW-1:0]      status;
    logic [OccW-1:0]         occupancy;
  } result_t;

  logic clk_i;
  logic rst_ni;

  bdq_req_if req_if ();
  bdq_rsp_if rsp_if ();

  bounded_deque_with_index_read_core DUT (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (req_if),
    .rsp_o (rsp_if)
  );

  op_item_t op_q[$];
  result_t  result_q[$];

  // deque model
  logic signed [DataW-1:0] deque_mem [Capacity];
  int unsigned             front_slot;
  int unsigned             held;

  // stimulus shaping
  int unsigned gen_held;
  int unsigned gap_pct;
  bit          hold_next;
  int unsigned stall_pct;
  int unsigned stall_left;
  int unsigned phase_cycles;

  int unsigned cycles;
  int unsigned errors;
  bit          req_fire;

  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  function automatic result_t apply_op(op_item_t op);
    result_t r;
    r.read_value = '0;
    r.status     = StatusDone;
    case (op.func)
      FuncPushFront, FuncPushBack: begin
        if (held >= Capacity) begin
          r.status = StatusFull;
        end else begin
          if (op.func == FuncPushFront) begin
            front_slot            = (front_slot + Capacity - 1) % Capacity;
            deque_mem[front_slot] = op.value;
          end else begin
            deque_mem[(front_slot + held) % Capacity] = op.value;
          end
          held++;
        end
      end
      FuncPopFront, FuncPopBack: begin
        if (held == 0) begin
          r.status = StatusEmpty;
        end else begin
          if (op.func == FuncPopFront) begin
            front_slot = (front_slot + 1) % Capacity;
          end
          held--;
        end
      end
      FuncReadIndex: begin
        if (int'(op.position) >= int'(held)) begin
          r.read_value = -1;
          r.status     = StatusEmpty;
        end else begin
          r.read_value = deque_mem[(front_slot + op.position) % Capacity];
        end
      end
      default: ;
    endcase
    r.occupancy = OccW'(held);
    return r;
  endfunction

  function automatic logic signed [DataW-1:0] pick_value();
    case ($urandom_range(0, 9))
      0:       return 32'sh7fffffff;
      1:       return 32'sh80000000;
      2:       return -1;
      3:       return 0;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [PosW-1:0] pick_read_pos();
    if (gen_held > 0 && $urandom_range(0, 3) != 0) begin
      return PosW'($urandom_range(0, gen_held - 1));
    end
    case ($urandom_range(0, 2))
      0:       return PosW'(gen_held);
      1:       return '1;
      default: return PosW'($urandom);
    endcase
  endfunction

  task automatic queue_op(logic [FuncW-1:0] f, logic signed [DataW-1:0] v,
                          logic [PosW-1:0] p);
    op_item_t it;
    it.func     = f;
    it.value    = v;
    it.position = p;
    it.hold     = hold_next;
    it.gap      = 0;
    hold_next   = 1'b0;
    if ($urandom_range(0, 99) < gap_pct) begin
      it.gap = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 30) : $urandom_range(1, 3);
    end
    case (f)
      FuncPushFront, FuncPushBack: if (gen_held < Capacity) gen_held++;
      FuncPopFront, FuncPopBack:   if (gen_held > 0) gen_held--;
      default: ;
    endcase
    op_q.push_back(it);
  endtask

  task automatic random_op(int unsigned push_pct, int unsigned pop_pct);
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 3) begin
      queue_op(FuncW'(int'(FuncReadIndex) + $urandom_range(1, 3)), $urandom, PosW'($urandom));
    end else if (roll < 3 + push_pct) begin
      queue_op($urandom_range(0, 1) ? FuncPushBack : FuncPushFront, pick_value(),
               PosW'($urandom));
    end else if (roll < 3 + push_pct + pop_pct) begin
      queue_op($urandom_range(0, 1) ? FuncPopBack : FuncPopFront, $urandom, PosW'($urandom));
    end else begin
      queue_op(FuncReadIndex, $urandom, pick_read_pos());
    end
  endtask

  // driver
  always @(negedge clk_i) begin
    op_item_t it;
    if (rst_ni && (req_fire || !req_if.valid)) begin
      if (op_q.size() == 0) begin
        req_if.valid <= 1'b0;
      end else if (op_q[0].gap > 0) begin
        op_q[0].gap  = op_q[0].gap - 1;
        req_if.valid <= 1'b0;
      end else if (op_q[0].hold && result_q.size() != 0) begin
        req_if.valid <= 1'b0;
      end else begin
        it = op_q.pop_front();
        req_if.valid    <= 1'b1;
        req_if.func     <= it.func;
        req_if.value    <= it.value;
        req_if.position <= it.position;
      end
    end
  end

  // result side stalls
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (phase_cycles == 0) begin
        phase_cycles = 300;
        case ($urandom_range(0, 2))
          0:       stall_pct = 0;
          1:       stall_pct = 15;
          default: stall_pct = 50;
        endcase
      end else begin
        phase_cycles--;
      end
      if (stall_left > 0) begin
        stall_left--;
        rsp_if.ready <= 1'b0;
      end else if ($urandom_range(0, 99) < stall_pct) begin
        stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(0, 2);
        rsp_if.ready <= 1'b0;
      end else begin
        rsp_if.ready <= 1'b1;
      end
    end
  end

  // monitor
  always @(posedge clk_i) begin
    op_item_t it;
    result_t  exp_r;
    if (rst_ni) begin
      cycles++;
      if (cycles > CycleLimit) begin
        $display("Test completed with failures");
        $finish;
      end
      if (rsp_if.valid && rsp_if.ready) begin
        if (result_q.size() == 0) begin
          errors++;
          if (errors <= MaxReports) begin
            $display("unexpected result item: read_value %0d status %0d occupancy %0d",
                     rsp_if.read_value, rsp_if.status, rsp_if.occupancy);
          end
        end else begin
          exp_r = result_q.pop_front();
          if (rsp_if.read_value !== exp_r.read_value || rsp_if.status !== exp_r.status ||
              rsp_if.occupancy !== exp_r.occupancy) begin
            errors++;
            if (errors <= MaxReports) begin
              $display("mismatch at cycle %0d: expected %0d/%0d/%0d got %0d/%0d/%0d",
                       cycles, exp_r.read_value, exp_r.status, exp_r.occupancy,
                       rsp_if.read_value, rsp_if.status, rsp_if.occupancy);
            end
          end
        end
      end
      if (req_if.valid && req_if.ready) begin
        it.func     = req_if.func;
        it.value    = req_if.value;
        it.position = req_if.position;
        it.gap      = 0;
        it.hold     = 1'b0;
        result_q.push_back(apply_op(it));
      end
      req_fire <= req_if.valid && req_if.ready;
    end
  end

  initial begin
    rst_ni          = 1'b0;
    req_if.valid    = 1'b0;
    req_if.func     = '0;
    req_if.value    = '0;
    req_if.position = '0;
    rsp_if.ready    = 1'b0;
    req_fire        = 1'b0;
    front_slot      = 0;
    held            = 0;
    gen_held        = 0;
    hold_next       = 1'b0;
    stall_pct       = 0;
    stall_left      = 0;
    phase_cycles    = 0;
    cycles          = 0;
    errors          = 0;

    // directed: empty edges, spare codes, extremes, wrap of the front slot
    gap_pct = 30;
    queue_op(FuncReadIndex, 0, 0);
    queue_op(FuncPopFront, 0, 0);
    queue_op(FuncPopBack, 0, 0);
    for (int c = int'(FuncReadIndex) + 1; c < (1 << FuncW); c++) begin
      queue_op(FuncW'(c), '1, '1);
    end
    queue_op(FuncPushFront, 32'sh7fffffff, '1);
    queue_op(FuncPushBack, 32'sh80000000, 0);
    queue_op(FuncPushFront, -1, 0);
    queue_op(FuncPushBack, 0, 0);
    for (int i = 0; i < 4; i++) begin
      queue_op(FuncReadIndex, 0, PosW'(i));
    end
    queue_op(FuncReadIndex, 0, 4);
    queue_op(FuncReadIndex, 0, '1);
    queue_op(FuncPopBack, 0, 0);
    queue_op(FuncPopFront, 0, 0);
    queue_op(FuncReadIndex, 0, 0);
    queue_op(FuncReadIndex, 0, 1);
    queue_op(FuncPopFront, 0, 0);
    queue_op(FuncPopBack, 0, 0);
    queue_op(FuncPopBack, 0, 0);

    // random mix at low fill
    for (int i = 0; i < 40; i++) begin
      random_op(40, 30);
    end

    // fill to capacity, push into the full queue, read at the end
    hold_next = 1'b1;
    gap_pct   = 20;
    while (gen_held < Capacity) begin
      random_op(85, 5);
    end
    for (int i = 0; i < 3; i++) begin
      queue_op($urandom_range(0, 1) ? FuncPushBack : FuncPushFront, pick_value(), 0);
    end
    queue_op(FuncReadIndex, 0, PosW'(Capacity - 1));
    queue_op(FuncReadIndex, 0, PosW'(Capacity));

    // drain to empty and pop past it
    while (gen_held > 0) begin
      random_op(5, 85);
    end
    queue_op(FuncPopFront, 0, 0);
    queue_op(FuncPopBack, 0, 0);

    // back-to-back stretch
    hold_next = 1'b1;
    gap_pct   = 0;
    for (int i = 0; i < 40; i++) begin
      random_op(40, 30);
    end

    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    while (op_q.size() != 0 || req_if.valid || result_q.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (10) @(posedge clk_i);

    if (errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
